// ----- hw/rtl/iarc_pkg.sv -----
// ----------------------------------------------------------------------------
// iarc_pkg - shared types and codes of the atlas refcount cache
// Operation and status codes, register indexes and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package iarc_pkg;

  // operation codes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_MARK    = 2'd2;
  localparam logic [1:0] OP_EVICT   = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_ATLAS_FULL = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

  // register indexes
  localparam logic [1:0] REG_ATLAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_ATLAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAX_AGE      = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the input transaction, clear scan state
    logic scan;     // examine the entry at the scan index
    logic scan_adv; // step the scan index
    logic finish;   // apply the result and write back
  } iarc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last; // registered read is at the last entry
    logic found;     // key hit seen during the scan
  } iarc_stat_t;

endpackage

// ----- hw/rtl/iarc_ctrl.sv -----
// ----------------------------------------------------------------------------
// iarc_ctrl - transaction sequencer
// Accepts one transaction, walks the entry table through the datapath,
// then holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module iarc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output iarc_pkg::iarc_cmd_t  cmd,
  input  iarc_pkg::iarc_stat_t stat
);
  import iarc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;
  state_t state;

  // result register frees when taken, so a new transaction may enter meanwhile
  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.scan     = (state == S_SCAN);
    cmd.scan_adv = (state == S_SCAN) && !stat.scan_last;
    cmd.finish   = (state == S_FINISH) && out_free;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE:   if (in_valid) state <= S_SCAN;
        S_SCAN:   if (stat.scan_last) state <= S_FINISH;
        S_FINISH: if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/iarc_dp.sv -----
// ----------------------------------------------------------------------------
// iarc_dp - entry table, shelf packer and result register
// The table sits in a memory read at the scan index; valid bits and the
// packer cursors are flip-flops.
// ----------------------------------------------------------------------------
module iarc_dp #(
  parameter int ENTRIES = 64,
  parameter int MAX_DIM = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  iarc_pkg::iarc_cmd_t  cmd,
  output iarc_pkg::iarc_stat_t stat,
  input  logic [12:0]        atlas_width,
  input  logic [12:0]        atlas_height,
  input  logic [31:0]        max_age,
  input  logic [1:0]         op,
  input  logic [63:0]        key,
  input  logic [15:0]        req_width,
  input  logic [15:0]        req_height,
  input  logic [31:0]        frame,
  output logic [2:0]         status,
  output logic               hit,
  output logic [11:0]        region_x,
  output logic [11:0]        region_y,
  output logic [12:0]        region_w,
  output logic [12:0]        region_h,
  output logic [6:0]         evicted_count
);
  import iarc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam logic [12:0] MAXD = 13'(MAX_DIM > 4096 ? 4096 : MAX_DIM);

  typedef struct packed {
    logic [63:0] key;
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
    logic [15:0] refs;
    logic [31:0] last;
  } entry_t;

  entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  entry_t rd;

  // captured transaction
  logic [1:0]  t_op;
  logic [63:0] t_key;
  logic [15:0] t_w, t_h;
  logic [31:0] t_frame;

  // scan state: index is one ahead of the registered read
  logic [IW-1:0] sidx, ridx;
  logic          rvalid_rd;
  logic          found, free_seen;
  logic [IW-1:0] found_idx, free_idx;
  entry_t        found_e;
  logic [CW-1:0] evicted;

  logic [12:0] cursor_x, cursor_y, row_height;

  assign stat.scan_last = (ridx == LAST) && rvalid_rd;
  assign stat.found     = found;

  // scan index and registered memory read
  always_ff @(posedge clk) begin
    rd <= mem[sidx];
    if (cmd.load) begin
      sidx      <= '0;
      rvalid_rd <= 1'b0;
    end else if (cmd.scan) begin
      rvalid_rd <= 1'b1;
      ridx      <= sidx;
      if (cmd.scan_adv) sidx <= sidx + 1'b1;
    end
  end

  // evict test of the entry under the scan
  logic stale;
  logic [31:0] age;
  assign age   = t_frame - rd.last;
  assign stale = valid[ridx] && (rd.refs == 16'd0) && (t_frame > rd.last) && (age > max_age);

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_op <= op; t_key <= key; t_w <= req_width; t_h <= req_height; t_frame <= frame;
      found <= 1'b0; free_seen <= 1'b0; evicted <= '0;
    end else if (cmd.scan && rvalid_rd) begin
      if (valid[ridx] && rd.key == t_key && !found) begin
        found     <= 1'b1;
        found_idx <= ridx;
        found_e   <= rd;
      end
      if (!valid[ridx] && !free_seen) begin
        free_seen <= 1'b1;
        free_idx  <= ridx;
      end
      if (t_op == OP_EVICT && stale) evicted <= evicted + 1'b1;
    end
  end

  // packer decision
  logic [12:0] aw, ah;
  logic [13:0] tall, cx_w, cy_t, ncy, ncy_h;
  logic bad, fit_cur, fit_new;
  assign aw = (atlas_width  > MAXD) ? MAXD : atlas_width;
  assign ah = (atlas_height > MAXD) ? MAXD : atlas_height;
  assign bad = (t_w == 16'd0) || (t_h == 16'd0) || (t_w > {3'd0, aw}) || (t_h > {3'd0, ah});
  assign tall  = (t_h[12:0] > row_height) ? {1'b0, t_h[12:0]} : {1'b0, row_height};
  assign cx_w  = {1'b0, cursor_x} + {1'b0, t_w[12:0]};
  assign cy_t  = {1'b0, cursor_y} + tall;
  assign fit_cur = (cx_w <= {1'b0, aw}) && (cy_t <= {1'b0, ah});
  assign ncy   = {1'b0, cursor_y} + {1'b0, row_height};
  assign ncy_h = {1'b0, ncy[12:0]} + {1'b0, t_h[12:0]};
  assign fit_new = ncy_h <= {1'b0, ah};

  // finish: result, table and packer update; evict clears valid bits during the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      cursor_x   <= '0;
      cursor_y   <= '0;
      row_height <= '0;
    end else if (cmd.finish) begin
      status <= ST_OK; hit <= 1'b0; region_x <= '0; region_y <= '0;
      region_w <= '0; region_h <= '0; evicted_count <= '0;
      case (t_op)
        OP_ALLOC: begin
          if (found) begin
            hit <= 1'b1;
            region_x <= found_e.x; region_y <= found_e.y;
            region_w <= found_e.w; region_h <= found_e.h;
            if (found_e.refs != 16'hFFFF) mem[found_idx].refs <= found_e.refs + 16'd1;
          end else if (bad) begin
            status <= ST_BAD_SIZE;
          end else if (!free_seen) begin
            status <= ST_TABLE_FULL;
          end else if (fit_cur || fit_new) begin
            valid[free_idx] <= 1'b1;
            mem[free_idx] <= '{key: t_key,
                               x: fit_cur ? cursor_x[11:0] : 12'd0,
                               y: fit_cur ? cursor_y[11:0] : ncy[11:0],
                               w: t_w[12:0], h: t_h[12:0], refs: 16'd1, last: 32'd0};
            region_x <= fit_cur ? cursor_x[11:0] : 12'd0;
            region_y <= fit_cur ? cursor_y[11:0] : ncy[11:0];
            region_w <= t_w[12:0];
            region_h <= t_h[12:0];
            cursor_x   <= fit_cur ? cx_w[12:0] : t_w[12:0];
            cursor_y   <= fit_cur ? cursor_y : ncy[12:0];
            row_height <= fit_cur ? tall[12:0] : t_h[12:0];
          end else begin
            status     <= ST_ATLAS_FULL;
            cursor_x   <= '0;
            cursor_y   <= ncy[12:0];
            row_height <= '0;
          end
        end
        OP_RELEASE, OP_MARK: begin
          if (!found) status <= ST_NOT_FOUND;
          else begin
            hit <= 1'b1;
            if (t_op == OP_RELEASE) begin
              if (found_e.refs != 16'd0) mem[found_idx].refs <= found_e.refs - 16'd1;
            end else begin
              mem[found_idx].last <= t_frame;
            end
          end
        end
        default: evicted_count <= 7'(evicted);
      endcase
    end else if (cmd.scan && rvalid_rd && t_op == OP_EVICT && stale) begin
      valid[ridx] <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/image_atlas_refcount_cache.sv -----
// ----------------------------------------------------------------------------
// image_atlas_refcount_cache - keyed texture atlas cache with shelf packer
//
//  channel | handshake               | payload
//  in      | in_valid / in_stall     | op key req_width req_height frame
//  out     | out_valid / out_stall   | status hit region_* evicted_count
//  cfg     | APB psel/penable/pwrite | paddr pwdata prdata
//
// Each transaction is accepted, then walks the entry memory (one read port),
// then is written back.
// Reset clears the valid bits and packer cursors and loads the config defaults.
// A held result blocks write-back of the next transaction until taken.
// ----------------------------------------------------------------------------
module image_atlas_refcount_cache #(
  parameter int ENTRIES = 64,
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [63:0] key,
  input  logic [15:0] req_width,
  input  logic [15:0] req_height,
  input  logic [31:0] frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        hit,
  output logic [11:0] region_x,
  output logic [11:0] region_y,
  output logic [12:0] region_w,
  output logic [12:0] region_h,
  output logic [6:0]  evicted_count
);
  import iarc_pkg::*;

  logic [12:0] atlas_width, atlas_height;
  logic [31:0] max_age;
  iarc_cmd_t  cmd;
  iarc_stat_t stat;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= 13'd4096;
      atlas_height <= 13'd4096;
      max_age      <= 32'd60;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_ATLAS_WIDTH:  atlas_width  <= pwdata[12:0];
        REG_ATLAS_HEIGHT: atlas_height <= pwdata[12:0];
        REG_MAX_AGE:      max_age      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ATLAS_WIDTH:  prdata = {19'd0, atlas_width};
      REG_ATLAS_HEIGHT: prdata = {19'd0, atlas_height};
      REG_MAX_AGE:      prdata = max_age;
      default:          prdata = '0;
    endcase
  end

  iarc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  iarc_dp #(.ENTRIES(ENTRIES), .MAX_DIM(MAX_DIM)) u_dp (
    .clk, .rst, .cmd, .stat, .atlas_width, .atlas_height, .max_age,
    .op, .key, .req_width, .req_height, .frame,
    .status, .hit, .region_x, .region_y, .region_w, .region_h, .evicted_count
  );

endmodule

// ----- hw/rtl/iarc_checker.sv -----
// ----------------------------------------------------------------------------
// iarc_checker - port-level checks of the atlas cache
// Result rules seen from the ports, bound to the top level.
// ----------------------------------------------------------------------------
module iarc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic        hit,
  input logic [11:0] region_x,
  input logic [12:0] region_w,
  input logic [6:0]  evicted_count
);
  import iarc_pkg::*;

  // a stalled input transaction stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("input dropped under stall");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("result changed under stall");

  // a hit always reports ok
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> status == ST_OK)
    else $error("hit with error status");

  // failed results carry no region
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> region_w == 13'd0 && region_x == 12'd0)
    else $error("region on failure");

  // evict count and hit never together
  a_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_count != 7'd0 |-> !hit && status == ST_OK)
    else $error("bad evict result");

endmodule

bind image_atlas_refcount_cache iarc_checker u_iarc_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .status, .hit, .region_x, .region_w, .evicted_count
);

// ----- tb/sv/image_atlas_refcount_cache_tb.sv -----
// ----------------------------------------------------------------------------
// image_atlas_refcount_cache_tb - self-checking bench for the atlas cache
// Drives allocate, release, mark-used and evict transactions with random
// gaps and output stalls, predicts every result with a behavioral copy of
// the cache and shelf packer, and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module image_atlas_refcount_cache_tb;
  import iarc_pkg::*;

  localparam int NSLOT = 64;
  localparam int DIM_MAX = 4096;
  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 200;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] frame;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
    logic [6:0]  evicted;
  } rsp_t;

  // directed row: request plus optional typed-in result
  typedef struct packed {
    req_t req;
    logic fixed;
    rsp_t rsp;
  } row_t;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_stall;
  logic [1:0]  op;
  logic [63:0] key;
  logic [15:0] req_width, req_height;
  logic [31:0] frame;
  logic        out_valid, out_stall;
  logic [2:0]  status;
  logic        hit;
  logic [11:0] region_x, region_y;
  logic [12:0] region_w, region_h;
  logic [6:0]  evicted_count;

  image_atlas_refcount_cache u_dut (.*);

  // predictor state
  logic [12:0] atlas_w_reg, atlas_h_reg;
  logic [31:0] age_limit;
  logic        slot_used [NSLOT];
  logic [63:0] slot_key [NSLOT];
  logic [11:0] slot_x [NSLOT], slot_y [NSLOT];
  logic [12:0] slot_w [NSLOT], slot_h [NSLOT];
  logic [15:0] slot_refs [NSLOT];
  logic [31:0] slot_seen [NSLOT];
  logic [12:0] shelf_x, shelf_y, shelf_h;

  rsp_t   expected_q[$];
  logic   fixed_q[$];
  rsp_t   fixed_rsp_q[$];
  logic [63:0] live_keys[$];
  int     errors, sent, got, idle_cycles, rx_stall_left;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog on cycles with no accepted transaction and no taken result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [12:0] clamp_dim(logic [12:0] v);
    return (v > DIM_MAX) ? 13'(DIM_MAX) : v;
  endfunction

  function automatic int lookup_slot(logic [63:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (slot_used[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  // cache and shelf packer prediction for one transaction
  function automatic rsp_t predict_cache(req_t r);
    rsp_t o;
    int idx, slot;
    logic [31:0] aw, ah, tall, cx, cy;
    logic placed;
    o = '0;
    idx = lookup_slot(r.key);
    case (r.op)
      OP_ALLOC: begin
        if (idx >= 0) begin
          o.hit = 1;
          if (slot_refs[idx] != 16'hFFFF) slot_refs[idx]++;
          o.x = slot_x[idx]; o.y = slot_y[idx];
          o.w = slot_w[idx]; o.h = slot_h[idx];
        end else begin
          aw = clamp_dim(atlas_w_reg);
          ah = clamp_dim(atlas_h_reg);
          slot = -1;
          for (int i = NSLOT - 1; i >= 0; i--) if (!slot_used[i]) slot = i;
          if (r.w == 0 || r.h == 0 || r.w > aw || r.h > ah) begin
            o.status = ST_BAD_SIZE;
          end else if (slot < 0) begin
            o.status = ST_TABLE_FULL;
          end else begin
            tall = (r.h > shelf_h) ? r.h : shelf_h;
            placed = 0;
            if (shelf_x + r.w <= aw && shelf_y + tall <= ah) begin
              cx = shelf_x; cy = shelf_y;
              shelf_x = 13'(shelf_x + r.w);
              shelf_h = 13'(tall);
              placed = 1;
            end else begin
              shelf_y = 13'(shelf_y + shelf_h);
              shelf_x = 0;
              shelf_h = 0;
              if (r.w <= aw && shelf_y + r.h <= ah) begin
                cx = 0; cy = shelf_y;
                shelf_x = 13'(r.w);
                shelf_h = 13'(r.h);
                placed = 1;
              end
            end
            if (placed) begin
              o.x = 12'(cx); o.y = 12'(cy);
              o.w = 13'(r.w); o.h = 13'(r.h);
              slot_used[slot] = 1;
              slot_key[slot] = r.key;
              slot_x[slot] = o.x; slot_y[slot] = o.y;
              slot_w[slot] = o.w; slot_h[slot] = o.h;
              slot_refs[slot] = 1;
              slot_seen[slot] = 0;
              live_keys.push_back(r.key);
            end else begin
              o.status = ST_ATLAS_FULL;
            end
          end
        end
      end
      OP_RELEASE, OP_MARK: begin
        if (idx < 0) begin
          o.status = ST_NOT_FOUND;
        end else begin
          o.hit = 1;
          if (r.op == OP_RELEASE) begin
            if (slot_refs[idx] != 0) slot_refs[idx]--;
          end else begin
            slot_seen[idx] = r.frame;
          end
        end
      end
      default: begin
        for (int i = 0; i < NSLOT; i++)
          if (slot_used[i] && slot_refs[i] == 0 && r.frame > slot_seen[i] &&
              r.frame - slot_seen[i] > age_limit) begin
            slot_used[i] = 0;
            o.evicted++;
          end
      end
    endcase
    return o;
  endfunction

  // register write over the config port, block must be idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_ATLAS_WIDTH:  atlas_w_reg = val[12:0];
      REG_ATLAS_HEIGHT: atlas_h_reg = val[12:0];
      default:          age_limit = val;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (NSLOT + 8) @(posedge clk);
  endtask

  // one input transaction with a random lead gap
  task automatic send_req(req_t r, logic fixed, rsp_t frsp);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    op <= r.op; key <= r.key; req_width <= r.w; req_height <= r.h;
    frame <= r.frame;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_cache(r));
    fixed_q.push_back(fixed);
    fixed_rsp_q.push_back(frsp);
    sent++;
  endtask

  // result side: random stalls, compare with oldest expectation
  initial begin
    rx_stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        rsp_t e, a;
        logic f;
        rsp_t fr;
        a = '{status, hit, region_x, region_y, region_w, region_h, evicted_count};
        got++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          f = fixed_q.pop_front();
          fr = fixed_rsp_q.pop_front();
          if (f && fr != e) begin
            $error("typed result %h differs from prediction %h", fr, e);
            errors++;
          end
          if (a.status != e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++;
          end
          if (a.hit != e.hit) begin
            $error("hit exp %0d got %0d", e.hit, a.hit); errors++;
          end
          if (a.x != e.x) begin
            $error("region_x exp %0d got %0d", e.x, a.x); errors++;
          end
          if (a.y != e.y) begin
            $error("region_y exp %0d got %0d", e.y, a.y); errors++;
          end
          if (a.w != e.w) begin
            $error("region_w exp %0d got %0d", e.w, a.w); errors++;
          end
          if (a.h != e.h) begin
            $error("region_h exp %0d got %0d", e.h, a.h); errors++;
          end
          if (a.evicted != e.evicted) begin
            $error("evicted_count exp %0d got %0d", e.evicted, a.evicted);
            errors++;
          end
        end
        rx_stall_left = $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
      end
      if (rx_stall_left > 0) begin
        out_stall <= 1;
        rx_stall_left--;
      end else begin
        out_stall <= 0;
      end
    end
  end

  function automatic req_t rand_req(int phase);
    req_t r;
    int pick;
    r.key = {$urandom, $urandom};
    if (live_keys.size() != 0 && $urandom_range(0, 9) < 7)
      r.key = live_keys[$urandom_range(0, live_keys.size() - 1)];
    r.frame = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400);
    pick = $urandom_range(0, 99);
    r.op = pick < 45 ? OP_ALLOC : pick < 70 ? OP_RELEASE : pick < 92 ? OP_MARK : OP_EVICT;
    if ($urandom_range(0, 19) == 0) begin
      r.w = 16'($urandom); r.h = 16'($urandom);
    end else if (phase == 1) begin
      r.w = 16'($urandom_range(0, 40)); r.h = 16'($urandom_range(0, 40));
    end else begin
      r.w = 16'($urandom_range(1, 700)); r.h = 16'($urandom_range(1, 500));
    end
    return r;
  endfunction

  row_t directed [];
  rsp_t z;

  initial begin
    errors = 0; sent = 0; got = 0; idle_cycles = 0;
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; op = OP_ALLOC; key = '0; req_width = '0; req_height = '0;
    frame = '0; out_stall = 0;
    atlas_w_reg = 13'd4096; atlas_h_reg = 13'd4096; age_limit = 32'd60;
    for (int i = 0; i < NSLOT; i++) begin
      slot_used[i] = 0; slot_key[i] = '0; slot_x[i] = '0; slot_y[i] = '0;
      slot_w[i] = '0; slot_h[i] = '0; slot_refs[i] = '0; slot_seen[i] = '0;
    end
    shelf_x = 0; shelf_y = 0; shelf_h = 0;
    z = '0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed rows: sizes, hits, misses, evict and saturation paths
    directed = '{
      '{'{OP_RELEASE, 64'h1, 16'd0, 16'd0, 32'd0}, 1'b1, '{ST_NOT_FOUND, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0, 7'd0}},
      '{'{OP_MARK, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 16'd0, 32'd5}, 1'b1, '{ST_NOT_FOUND, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0, 7'd0}},
      '{'{OP_ALLOC, 64'h10, 16'd0, 16'd8, 32'd0}, 1'b1, '{ST_BAD_SIZE, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0, 7'd0}},
      '{'{OP_ALLOC, 64'h10, 16'd8, 16'd0, 32'd0}, 1'b1, '{ST_BAD_SIZE, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0, 7'd0}},
      '{'{OP_ALLOC, 64'h10, 16'hFFFF, 16'd8, 32'd0}, 1'b1, '{ST_BAD_SIZE, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0, 7'd0}},
      '{'{OP_ALLOC, 64'h10, 16'd8, 16'd4097, 32'd0}, 1'b1, '{ST_BAD_SIZE, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0, 7'd0}},
      '{'{OP_ALLOC, 64'h10, 16'd100, 16'd50, 32'd0}, 1'b1, '{ST_OK, 1'b0, 12'd0, 12'd0, 13'd100, 13'd50, 7'd0}},
      '{'{OP_ALLOC, 64'h10, 16'd1, 16'd1, 32'd0}, 1'b1, '{ST_OK, 1'b1, 12'd0, 12'd0, 13'd100, 13'd50, 7'd0}},
      '{'{OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 16'd3996, 16'd20, 32'd0}, 1'b0, z},
      '{'{OP_ALLOC, 64'h20, 16'd4096, 16'd4096, 32'd0}, 1'b0, z},
      '{'{OP_ALLOC, 64'h30, 16'd4096, 16'd1, 32'd0}, 1'b0, z},
      '{'{OP_RELEASE, 64'h10, 16'd0, 16'd0, 32'd0}, 1'b0, z},
      '{'{OP_RELEASE, 64'h10, 16'd0, 16'd0, 32'd0}, 1'b0, z},
      '{'{OP_RELEASE, 64'h10, 16'd0, 16'd0, 32'd0}, 1'b0, z},
      '{'{OP_MARK, 64'h10, 16'd0, 16'd0, 32'hFFFF_FF00}, 1'b0, z},
      '{'{OP_EVICT, 64'h0, 16'd0, 16'd0, 32'hFFFF_FF3C}, 1'b0, z},
      '{'{OP_EVICT, 64'h0, 16'd0, 16'd0, 32'hFFFF_FFFF}, 1'b0, z},
      '{'{OP_EVICT, 64'h0, 16'd0, 16'd0, 32'd0}, 1'b1, '{ST_OK, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0, 7'd0}}
    };
    foreach (directed[i]) send_req(directed[i].req, directed[i].fixed, directed[i].rsp);

    // raise one reference count with repeated hits
    for (int i = 0; i < 3; i++) send_req('{OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 16'd1, 32'd0}, 0, z);

    // phases of register settings, random traffic in each
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: begin write_reg(REG_ATLAS_WIDTH, 32'd1); write_reg(REG_ATLAS_HEIGHT, 32'd1);
             write_reg(REG_MAX_AGE, 32'd0); end
        1: begin write_reg(REG_ATLAS_WIDTH, 32'd128); write_reg(REG_ATLAS_HEIGHT, 32'd96);
             write_reg(REG_MAX_AGE, 32'd20); end
        2: begin write_reg(REG_ATLAS_WIDTH, 32'd8191); write_reg(REG_ATLAS_HEIGHT, 32'd8191);
             write_reg(REG_MAX_AGE, 32'hFFFF_FFFF); end
        3: begin write_reg(REG_ATLAS_WIDTH, 32'd0); write_reg(REG_ATLAS_HEIGHT, 32'd4096);
             write_reg(REG_MAX_AGE, 32'd5); end
        4: begin write_reg(REG_ATLAS_WIDTH, 32'hFFFF_E000 | 32'd4000);
             write_reg(REG_ATLAS_HEIGHT, 32'd4096); write_reg(REG_MAX_AGE, 32'd100); end
        default: begin write_reg(REG_ATLAS_WIDTH, 32'd4096);
             write_reg(REG_ATLAS_HEIGHT, 32'd4096); write_reg(REG_MAX_AGE, 32'd60); end
      endcase
      for (int n = 0; n < 210; n++) send_req(rand_req(ph < 4 ? 1 : 2), 0, z);
      // release live keys in odd phases so the table keeps turning over
      for (int n = 0; n < 64 && ph[0]; n++)
        if (live_keys.size() != 0)
          send_req('{OP_RELEASE, live_keys[$urandom_range(0, live_keys.size() - 1)],
                     16'd0, 16'd0, 32'd0}, 0, z);
      send_req('{OP_EVICT, 64'h0, 16'd0, 16'd0, 32'hFFFF_FFFF}, 0, z);
    end

    in_valid <= 0;
    fork
      begin
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
      end
      begin
        repeat (2000000) @(posedge clk);
        $display("TB_ERROR");
        $finish;
      end
    join_any
    $display("ran %0d transactions over six register settings, %0d results checked",
             sent, got);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
